// ===== hw/rtl/tgl_pkg.sv =====
// ----------------------------------------------------------------------------
// tgl_pkg: shared types and constants for the text glyph layout block
// Holds the controller states, command and status bundles and the fixed
// widths of the Q12.8 world lengths.
// ----------------------------------------------------------------------------
package tgl_pkg;

    localparam int MaxQuadsDefault = 64;

    localparam logic signed [19:0] QMax = 20'sh7FFFF;
    localparam logic signed [19:0] QMin = -20'sh80000;
    localparam logic [7:0] CodeCr    = 8'd13;
    localparam logic [7:0] CodeLf    = 8'd10;
    localparam logic [7:0] CodeSpace = 8'd32;
    localparam logic [7:0] PointTwo  = 8'd51;

    localparam logic [1:0] RegCharHeight    = 2'd0;
    localparam logic [1:0] RegLetterSpacing = 2'd1;
    localparam logic [1:0] RegLineSpacing   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PLACE,
        ST_EMIT_RD,
        ST_EMIT_WAIT,
        ST_EMIT_OUT
    } tgl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture the input item
        logic div_start;  // start both divisions
        logic place;      // update pen, extents, store quad
        logic line_feed;  // new line
        logic emit_read;  // read store at emit index
        logic out_load;   // register the output quad
        logic emit_next;  // advance emit index
        logic clear;      // start layout over
    } tgl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic is_cr;
        logic is_lf;
        logic is_glyph;
        logic is_last;
        logic have_quads;
        logic store_hit;  // placing now stores a quad
        logic emit_final;
    } tgl_status_t;

    function automatic logic signed [19:0] sat20(input logic signed [23:0] v);
        if (v > 24'(QMax))
            return QMax;
        else if (v < 24'(QMin))
            return QMin;
        else
            return v[19:0];
    endfunction

endpackage

// ===== hw/rtl/text_glyph_layout.sv =====
// ----------------------------------------------------------------------------
// text_glyph_layout: lays a text string out into centred glyph quads
// Takes one resolved character per transfer, stores a quad per visible glyph
// and on the last character sends every stored quad, centred on the text.
// ----------------------------------------------------------------------------
//
//  channel  | direction | content
//  ---------+-----------+----------------------------------------------------
//  s_axis   | in        | one character with glyph metrics, tlast = last_char
//  m_axis   | out       | one centred quad per transfer, tlast = last_quad
//  cfg      | in        | write-only: character height, letter and line gap
//
//  Flow: a glyph goes through capture, decode, the 24-step divider that
//  scales width and advance, and placement before the next input transfer;
//  line feed, carriage return and skipped items need only capture and decode.
//  On the last character each stored quad goes through the store read port
//  and output register, and waits while m_axis_tready is low.
//  Reset clears the pen, extents and quad count; the quad store needs none.
//  No input transfer is taken while quads are being sent.
//
module text_glyph_layout
    import tgl_pkg::*;
#(
    parameter int MAX_QUADS = MaxQuadsDefault
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // char_code[7:0], glyph_found[8], glyph_width_px[16:9],
    // glyph_height_px[24:17], advance_px[32:25], tex_min_u[48:33],
    // tex_min_v[64:49], tex_max_u[80:65], tex_max_v[96:81], zero fill
    input  logic [103:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // quad_x[19:0], quad_y[39:20], quad_width[58:40], quad_height[74:59],
    // out_min_u[90:75], out_min_v[106:91], out_max_u[122:107],
    // out_max_v[138:123], dropped[139], zero fill
    output logic [143:0] m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    tgl_cmd_t    cmd;
    tgl_status_t status;

    tgl_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
        .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
        .status(status), .cmd(cmd)
    );

    tgl_datapath #(.MAX_QUADS(MAX_QUADS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_data(s_axis_tdata), .in_last(s_axis_tlast),
        .out_data(m_axis_tdata), .out_last(m_axis_tlast)
    );

endmodule

// ===== hw/rtl/tgl_divider.sv =====
// ----------------------------------------------------------------------------
// tgl_divider: restoring divider, one quotient bit per cycle
// Divides a 24-bit unsigned numerator by an 8-bit nonzero divisor.
// ----------------------------------------------------------------------------
module tgl_divider
    import tgl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [23:0] numer,
    input  logic [7:0]  denom,
    output logic        done,
    output logic [23:0] quot
);

    logic [23:0] quot_reg, quot_next;
    logic [7:0]  rem_reg, rem_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [7:0]  den_reg;
    logic [8:0]  trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, quot_reg[23]};
        if (start)
        begin
            quot_next = numer;
            rem_next  = '0;
            cnt_next  = 5'd24;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = 8'(trial - {1'b0, den_reg});
                quot_next = {quot_reg[22:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[7:0];
                quot_next = {quot_reg[22:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (start)
            den_reg <= denom;
    end

    assign done = busy_reg && (cnt_reg == 5'd1);
    assign quot = quot_next;

endmodule

// ===== hw/rtl/tgl_datapath.sv =====
// ----------------------------------------------------------------------------
// tgl_datapath: pen, extents, quad store and output register
// Acts on controller commands; two dividers, one each, scale width and advance.
// ----------------------------------------------------------------------------
module tgl_datapath
    import tgl_pkg::*;
#(
    parameter int MAX_QUADS = MaxQuadsDefault,
    localparam int IdxW = (MAX_QUADS > 1) ? $clog2(MAX_QUADS) : 1,
    localparam int CntW = $clog2(MAX_QUADS + 1)
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  tgl_cmd_t     cmd,
    output tgl_status_t  status,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic [103:0] in_data,
    input  logic         in_last,
    output logic [143:0] out_data,
    output logic         out_last
);

    logic [15:0] height_reg;
    logic signed [15:0] letter_reg, line_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= 16'd256;
            letter_reg <= '0;
            line_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                RegCharHeight:    height_reg <= cfg_data;
                RegLetterSpacing: letter_reg <= cfg_data;
                RegLineSpacing:   line_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // captured item
    logic [7:0]  code_reg, wpx_reg, hpx_reg, apx_reg;
    logic        found_reg, last_reg;
    logic [63:0] tex_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            code_reg  <= in_data[7:0];
            found_reg <= in_data[8];
            wpx_reg   <= in_data[16:9];
            hpx_reg   <= in_data[24:17];
            apx_reg   <= in_data[32:25];
            tex_reg   <= in_data[96:33];
            last_reg  <= in_last;
        end
    end

    logic        wdone, adone;
    logic [23:0] wq, aq;
    logic [23:0] wprod, aprod;

    // glyph pixels times character height, divided by glyph pixel height
    assign wprod = 24'(wpx_reg) * 24'(height_reg);
    assign aprod = 24'(apx_reg) * 24'(height_reg);

    tgl_divider u_wdiv (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
        .numer(wprod), .denom(hpx_reg), .done(wdone), .quot(wq)
    );
    tgl_divider u_adiv (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
        .numer(aprod), .denom(hpx_reg), .done(adone), .quot(aq)
    );

    // width clamped to its 19-bit field, advance where any larger value saturates the pen anyway
    logic [18:0] w_reg;
    logic [20:0] a_reg;
    always_ff @(posedge clk)
    begin
        if (wdone)
        begin
            w_reg <= (wq > 24'h7FFFF) ? 19'h7FFFF : wq[18:0];
            a_reg <= (aq > 24'h1FFFFF) ? 21'h1FFFFF : aq[20:0];
        end
    end

    // layout state
    logic signed [19:0] pen_x_reg, pen_y_reg, ext_r_reg, ext_b_reg;
    logic signed [19:0] pen_x_next, right_v, bot_v, pen_y_lf;
    logic [CntW-1:0]    count_reg;
    logic               ovf_reg;
    logic [IdxW-1:0]    emit_reg;
    logic               emit_final;

    assign pen_x_next = sat20(24'(pen_x_reg) + $signed({3'd0, a_reg})
                              + 24'(letter_reg));
    assign right_v    = sat20(24'(pen_x_next) + $signed({5'd0, w_reg}));
    assign bot_v      = sat20(24'(pen_y_reg) - $signed({8'd0, height_reg}));
    assign pen_y_lf   = sat20(24'(pen_y_reg) - ($signed({8'd0, height_reg})
                              + 24'(line_reg) - $signed({16'd0, PointTwo})));

    logic store_q;
    assign store_q = (code_reg != CodeSpace) && (count_reg < CntW'(MAX_QUADS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg <= '0;
            pen_y_reg <= '0;
            ext_r_reg <= -20'sd256;
            ext_b_reg <= 20'sd256;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            emit_reg  <= '0;
        end
        else if (cmd.clear)
        begin
            pen_x_reg <= '0;
            pen_y_reg <= '0;
            ext_r_reg <= -20'sd256;
            ext_b_reg <= 20'sd256;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            emit_reg  <= '0;
        end
        else
        begin
            if (cmd.line_feed)
            begin
                pen_x_reg <= '0;
                pen_y_reg <= pen_y_lf;
            end
            if (cmd.place)
            begin
                pen_x_reg <= pen_x_next;
                if (right_v > ext_r_reg)
                    ext_r_reg <= right_v;
                if (bot_v < ext_b_reg)
                    ext_b_reg <= bot_v;
                if (store_q)
                    count_reg <= count_reg + CntW'(1);
                else if (code_reg != CodeSpace)
                    ovf_reg <= 1'b1;
            end
            if (cmd.emit_next)
                emit_reg <= emit_reg + IdxW'(1);
        end
    end

    // quad store: x, y, width, texture rectangle
    logic [122:0] mem [MAX_QUADS];
    logic [122:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.place && store_q)
            mem[count_reg[IdxW-1:0]] <= {tex_reg, w_reg, pen_y_reg, pen_x_reg};
        if (cmd.emit_read)
            rd_reg <= mem[emit_reg];
    end

    // centring: floor((2*pos - extent) / 2)
    logic signed [21:0] cx, cy;
    assign cx = (22'(signed'(rd_reg[19:0])) <<< 1) - 22'(ext_r_reg);
    assign cy = (22'(signed'(rd_reg[39:20])) <<< 1) - 22'(ext_b_reg);

    assign emit_final = ((CntW+1)'(emit_reg) + (CntW+1)'(1)) == (CntW+1)'(count_reg);

    logic [143:0] out_reg;
    logic         olast_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg <= {4'd0, ovf_reg, rd_reg[122:59], height_reg, rd_reg[58:40],
                        sat20(24'(cy >>> 1)), sat20(24'(cx >>> 1))};
            olast_reg <= emit_final;
        end
    end
    assign out_data = out_reg;
    assign out_last = olast_reg;

    assign status.div_done   = wdone & adone;
    assign status.is_cr      = code_reg == CodeCr;
    assign status.is_lf      = code_reg == CodeLf;
    assign status.is_glyph   = found_reg && (hpx_reg != 8'd0) && (height_reg != 16'd0);
    assign status.is_last    = last_reg;
    assign status.have_quads = count_reg != '0;
    assign status.store_hit  = store_q;
    assign status.emit_final = emit_final;

endmodule

// ===== hw/rtl/tgl_ctrl.sv =====
// ----------------------------------------------------------------------------
// tgl_ctrl: sequencer for the text glyph layout block
// Steps each item through decode, division, placement and the emit sweep.
// ----------------------------------------------------------------------------
module tgl_ctrl
    import tgl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  tgl_status_t status,
    output tgl_cmd_t    cmd
);

    tgl_state_t state_reg, state_next;
    logic       dec_reg, dec_next;
    logic       ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dec_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dec_reg   <= dec_next;
            ov_reg    <= ov_next;
        end
    end

    // dec_reg: item captured last cycle, decide in IDLE
    always_comb
    begin
        state_next = state_reg;
        dec_next   = 1'b0;
        ov_next    = ov_reg;
        if (m_tvalid && m_tready)
            ov_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (dec_reg)
                begin
                    if (!status.is_cr && !status.is_lf && status.is_glyph)
                        state_next = ST_DIV;
                    else if (status.is_last && status.have_quads)
                        state_next = ST_EMIT_RD;
                end
                else if (s_tvalid && !ov_reg)
                    dec_next = 1'b1;
            end
            ST_DIV:
                if (status.div_done)
                    state_next = ST_PLACE;
            ST_PLACE:
                if (status.is_last && (status.have_quads || status.store_hit))
                    state_next = ST_EMIT_RD;
                else
                    state_next = ST_IDLE;
            ST_EMIT_RD:
                state_next = ST_EMIT_WAIT;
            ST_EMIT_WAIT:
            begin
                if (!ov_reg || m_tready)
                begin
                    state_next = ST_EMIT_OUT;
                    ov_next    = 1'b1;
                end
            end
            ST_EMIT_OUT:
                state_next = status.emit_final ? ST_IDLE : ST_EMIT_RD;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = !dec_reg && !ov_reg;
                cmd.load = s_tvalid && !dec_reg && !ov_reg;
                if (dec_reg)
                begin
                    cmd.line_feed = status.is_lf;
                    cmd.div_start = !status.is_cr && !status.is_lf && status.is_glyph;
                    cmd.clear     = status.is_last && !cmd.div_start && !status.have_quads;
                end
            end
            ST_DIV: ;
            ST_PLACE:
            begin
                cmd.place = 1'b1;
                // last glyph of a text that holds no quad: start over now
                cmd.clear = status.is_last && !status.have_quads && !status.store_hit;
            end
            ST_EMIT_RD:
                cmd.emit_read = 1'b1;
            ST_EMIT_WAIT:
                cmd.out_load = !ov_reg || m_tready;
            ST_EMIT_OUT:
            begin
                cmd.emit_next = 1'b1;
                cmd.clear     = status.emit_final;
            end
            default: ;
        endcase
    end

    assign m_tvalid = ov_reg;

endmodule
